// ----- rtl/sss_pkg.sv -----
`default_nettype none

package sss_pkg;

	localparam int VAL_W      = 16;
	localparam int CHAN_W     = 4;
	localparam int IN_DATA_W  = 32;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 24;

	// 1.0 in Q4.12
	localparam logic signed [VAL_W-1:0] FT_GAIN_RST = 16'sd4096;

	typedef enum logic [1:0] {
		REQ_LOAD_A = 2'd0,
		REQ_LOAD_B = 2'd1,
		REQ_LOAD_C = 2'd2,
		REQ_SAMPLE = 2'd3
	} req_t;

	// second multiplier operand
	typedef enum logic [1:0] {
		OP_STATE = 2'd0,
		OP_U     = 2'd1,
		OP_NS    = 2'd2
	} op_t;

	typedef struct packed {
		logic fd_en;
		logic mul_en;
		op_t  op_sel;
		logic acc_clr;
		logic acc_en;
		logic ns_en;
	} mac_ctl_t;

	typedef struct packed {
		logic clear;
		logic commit;
		logic wr;
	} sst_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/sss_coef_mem.sv -----
`default_nettype none

module sss_coef_mem #(
	parameter int DEPTH = 288,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                            clk,
	input  logic                            wr_en,
	input  logic [AW-1:0]                   wr_addr,
	input  logic signed [sss_pkg::VAL_W-1:0] wr_data,
	input  logic                            rd_en,
	input  logic [AW-1:0]                   rd_addr,
	output logic signed [sss_pkg::VAL_W-1:0] rd_data
);
	import sss_pkg::*;

	logic signed [VAL_W-1:0] mem [DEPTH];
	logic signed [VAL_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

`default_nettype wire

// ----- rtl/sss_state_mem.sv -----
`default_nettype none

// two banks per row; sel_q marks the bank holding the current value, dirty_q
// marks a row whose next value sits in the other bank, zero_q marks a current
// value cleared by a sequence start
module sss_state_mem #(
	parameter int STATE_SIZE = 16,
	localparam int IW = (STATE_SIZE > 1) ? $clog2(STATE_SIZE) : 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  sss_pkg::sst_ctl_t               ctl,
	input  logic [IW-1:0]                   wr_row,
	input  logic signed [sss_pkg::VAL_W-1:0] wr_data,
	input  logic                            rd_en,
	input  logic [IW-1:0]                   rd_row,
	output logic signed [sss_pkg::VAL_W-1:0] rd_data
);
	import sss_pkg::*;

	logic signed [VAL_W-1:0] bank_mem [2][STATE_SIZE];
	logic [STATE_SIZE-1:0]   sel_q;
	logic [STATE_SIZE-1:0]   dirty_q;
	logic [STATE_SIZE-1:0]   zero_q;
	logic signed [VAL_W-1:0] rd_q;
	logic                    zero_s1;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			bank_mem[~sel_q[wr_row]][wr_row] <= wr_data;
		end
		if (rd_en) begin
			rd_q    <= bank_mem[sel_q[rd_row]][rd_row];
			zero_s1 <= zero_q[rd_row];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q   <= '0;
			dirty_q <= '0;
			zero_q  <= '1;
		end else begin
			if (ctl.clear) begin
				dirty_q <= '0;
				zero_q  <= '1;
			end else if (ctl.commit) begin
				// rows left untouched keep their bank, which still holds the current value
				sel_q   <= sel_q ^ dirty_q;
				zero_q  <= zero_q & ~dirty_q;
				dirty_q <= '0;
			end else if (ctl.wr) begin
				dirty_q[wr_row] <= 1'b1;
			end
		end
	end

	assign rd_data = zero_s1 ? '0 : rd_q;

endmodule

`default_nettype wire

// ----- rtl/sss_mac.sv -----
`default_nettype none

module sss_mac #(
	parameter int STATE_SIZE = 16,
	parameter int FRAC_BITS  = 12
) (
	input  logic                            clk,
	input  sss_pkg::mac_ctl_t               ctl,
	input  logic signed [sss_pkg::VAL_W-1:0] coef,
	input  logic signed [sss_pkg::VAL_W-1:0] st_val,
	input  logic signed [sss_pkg::VAL_W-1:0] u_val,
	input  logic signed [sss_pkg::VAL_W-1:0] gain,
	output logic signed [sss_pkg::VAL_W-1:0] ns_val,
	output logic signed [sss_pkg::VAL_W-1:0] y_val,
	output logic                            sat
);
	import sss_pkg::*;

	localparam int PROD_W = 2 * VAL_W;
	localparam int ACC_W  = PROD_W + 1 + $clog2(STATE_SIZE + 1);
	localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1 << (FRAC_BITS - 1));
	localparam logic signed [ACC_W-1:0] MAX_V = ACC_W'(32767);
	localparam logic signed [ACC_W-1:0] MIN_V = -ACC_W'(32768);

	logic signed [VAL_W-1:0]  opnd;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [PROD_W-1:0] fd_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [VAL_W-1:0]  ns_q;
	logic                     clip_q;
	logic [VAL_W:0]           ns_rs;
	logic [VAL_W:0]           y_rs;

	// round half up, drop the fraction, clip to 16 bits; msb is the clip flag
	function automatic logic [VAL_W:0] round_sat(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] r;
		r = (v + HALF) >>> FRAC_BITS;
		if (r > MAX_V) begin
			round_sat = {1'b1, MAX_V[VAL_W-1:0]};
		end else if (r < MIN_V) begin
			round_sat = {1'b1, MIN_V[VAL_W-1:0]};
		end else begin
			round_sat = {1'b0, r[VAL_W-1:0]};
		end
	endfunction

	always_comb begin
		case (ctl.op_sel)
			OP_STATE: opnd = st_val;
			OP_U:     opnd = u_val;
			OP_NS:    opnd = ns_q;
			default:  opnd = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_q <= coef * opnd;
		end
		if (ctl.fd_en) begin
			fd_q <= gain * u_val;
		end
		if (ctl.acc_clr) begin
			acc_q <= '0;
		end else if (ctl.acc_en) begin
			acc_q <= acc_q + ACC_W'(prod_q);
		end
		if (ctl.ns_en) begin
			ns_q   <= ns_rs[VAL_W-1:0];
			clip_q <= ns_rs[VAL_W];
		end
	end

	// the input coupling term is still in prod_q when the row sum is closed
	assign ns_rs  = round_sat(acc_q + ACC_W'(prod_q));
	assign ns_val = ns_rs[VAL_W-1:0];

	assign y_rs  = round_sat(ACC_W'(prod_q) + ACC_W'(fd_q));
	assign y_val = y_rs[VAL_W-1:0];
	assign sat   = y_rs[VAL_W] | clip_q;

endmodule

`default_nettype wire

// ----- rtl/state_space_scan_step_unit.sv -----
`default_nettype none

// State-space scan step in Q4.12. Load items (tuser 0, 1, 2) write one entry of
// A, B or C; they give no result. A sample item (tuser 3) for channel i walks
// row i of A against the current state with one shared multiply-accumulate, one
// coefficient memory read per cycle, then adds B[i]*u, writes the rounded and
// clipped new state and returns y = C[i]*x[i] + D*u. The STATE_SIZE row reads
// are followed by the B and C reads, then the write-back, C multiply and output
// states; the next item is taken only once the result is registered at the
// output, and later while an earlier result still waits there. Loads or samples
// whose index is outside STATE_SIZE are taken and dropped. Coefficients never
// written read as anything. A sequence start and a step end only update per-row
// flags on the two state banks, so they add no states. The feedthrough gain D
// resets to 1.0, is always ready and must be written only while no sample is in
// flight.
module state_space_scan_step_unit #(
	parameter int STATE_SIZE = 16,
	parameter int FRAC_BITS  = 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// row_index[3:0], col_index[7:4], item_value[23:8], sequence_start[24], zero
	input  logic [sss_pkg::IN_DATA_W-1:0]     s_tdata,
	// req_type[1:0]
	input  logic [sss_pkg::IN_USER_W-1:0]     s_tuser,
	input  logic                              s_tlast,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// output_value[15:0], out_channel[19:16], saturated[20], zero
	output logic [sss_pkg::OUT_DATA_W-1:0]    m_tdata,
	output logic                              m_tlast,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [sss_pkg::VAL_W-1:0]         cfg_data
);
	import sss_pkg::*;

	localparam int IW     = (STATE_SIZE > 1) ? $clog2(STATE_SIZE) : 1;
	localparam int DEPTH  = STATE_SIZE * STATE_SIZE + 2 * STATE_SIZE;
	localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW     = $clog2(STATE_SIZE + 2);
	localparam int B_BASE = STATE_SIZE * STATE_SIZE;
	localparam int C_BASE = STATE_SIZE * STATE_SIZE + STATE_SIZE;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_WB,
		ST_MULC,
		ST_OUT
	} state_t;

	state_t                  state_q;
	logic [CW-1:0]           cnt_q;
	logic [CHAN_W-1:0]       chan_q;
	logic signed [VAL_W-1:0] u_q;
	logic                    end_q;
	logic                    rd_a_s1;
	logic                    rd_b_s1;
	logic                    acc_a_s2;
	logic                    out_valid_q;
	logic signed [VAL_W-1:0] out_value_q;
	logic [CHAN_W-1:0]       out_chan_q;
	logic                    out_done_q;
	logic                    out_sat_q;
	logic signed [VAL_W-1:0] gain_q;

	req_t                    in_req;
	logic [CHAN_W-1:0]       in_row;
	logic [CHAN_W-1:0]       in_col;
	logic signed [VAL_W-1:0] in_val;
	logic                    in_start;
	logic                    in_row_ok;
	logic                    in_col_ok;
	logic                    accept;
	logic                    smp_go;
	logic [IW+CHAN_W-1:0]    in_row_ext;
	logic [IW+CHAN_W-1:0]    in_col_ext;
	logic [IW+CHAN_W-1:0]    row_ext;
	logic [IW-1:0]           row;

	logic                    cw_en;
	logic [AW-1:0]           cw_addr;
	logic [AW-1:0]           cr_addr;
	logic signed [VAL_W-1:0] coef;
	logic signed [VAL_W-1:0] st_val;
	logic signed [VAL_W-1:0] ns_val;
	logic signed [VAL_W-1:0] y_val;
	logic                    y_sat;
	logic                    st_rd_en;
	mac_ctl_t                mac_ctl;
	sst_ctl_t                st_ctl;

	assign in_req     = req_t'(s_tuser);
	assign in_row     = s_tdata[3:0];
	assign in_col     = s_tdata[7:4];
	assign in_val     = s_tdata[23:8];
	assign in_start   = s_tdata[24];
	assign in_row_ok  = 32'(in_row) < STATE_SIZE;
	assign in_col_ok  = 32'(in_col) < STATE_SIZE;
	assign in_row_ext = {{IW{1'b0}}, in_row};
	assign in_col_ext = {{IW{1'b0}}, in_col};
	assign row_ext    = {{IW{1'b0}}, chan_q};
	assign row        = row_ext[IW-1:0];

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign smp_go    = accept && in_row_ok && (in_req == REQ_SAMPLE);
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= FT_GAIN_RST;
		end else if (cfg_valid) begin
			gain_q <= cfg_data;
		end
	end

	// coefficient memory map: A rows, then B, then C
	always_comb begin
		cw_en   = 1'b0;
		cw_addr = '0;
		case (in_req)
			REQ_LOAD_A: begin
				cw_en   = accept && in_row_ok && in_col_ok;
				cw_addr = AW'(in_row_ext[IW-1:0]) * AW'(STATE_SIZE) + AW'(in_col_ext[IW-1:0]);
			end
			REQ_LOAD_B: begin
				cw_en   = accept && in_row_ok;
				cw_addr = AW'(B_BASE) + AW'(in_row_ext[IW-1:0]);
			end
			REQ_LOAD_C: begin
				cw_en   = accept && in_row_ok;
				cw_addr = AW'(C_BASE) + AW'(in_row_ext[IW-1:0]);
			end
			default: begin
				cw_en   = 1'b0;
				cw_addr = '0;
			end
		endcase
	end

	always_comb begin
		if (cnt_q < CW'(STATE_SIZE)) begin
			cr_addr = AW'(row) * AW'(STATE_SIZE) + AW'(cnt_q);
		end else if (cnt_q == CW'(STATE_SIZE)) begin
			cr_addr = AW'(B_BASE) + AW'(row);
		end else begin
			cr_addr = AW'(C_BASE) + AW'(row);
		end
	end

	assign st_rd_en = (state_q == ST_MAC) && (cnt_q < CW'(STATE_SIZE));

	always_comb begin
		mac_ctl.fd_en   = (state_q == ST_MAC) && (cnt_q == '0);
		mac_ctl.mul_en  = rd_a_s1 || rd_b_s1 || (state_q == ST_MULC);
		mac_ctl.op_sel  = rd_a_s1 ? OP_STATE : (rd_b_s1 ? OP_U : OP_NS);
		mac_ctl.acc_clr = accept;
		mac_ctl.acc_en  = acc_a_s2;
		mac_ctl.ns_en   = (state_q == ST_WB);
	end

	always_comb begin
		st_ctl.clear  = smp_go && in_start;
		st_ctl.commit = (state_q == ST_MULC) && end_q;
		st_ctl.wr     = (state_q == ST_WB);
	end

	sss_coef_mem #(
		.DEPTH(DEPTH)
	) u_coef_mem (
		.clk    (clk),
		.wr_en  (cw_en),
		.wr_addr(cw_addr),
		.wr_data(in_val),
		.rd_en  (state_q == ST_MAC),
		.rd_addr(cr_addr),
		.rd_data(coef)
	);

	sss_state_mem #(
		.STATE_SIZE(STATE_SIZE)
	) u_state_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (st_ctl),
		.wr_row (row),
		.wr_data(ns_val),
		.rd_en  (st_rd_en),
		.rd_row (cnt_q[IW-1:0]),
		.rd_data(st_val)
	);

	sss_mac #(
		.STATE_SIZE(STATE_SIZE),
		.FRAC_BITS (FRAC_BITS)
	) u_mac (
		.clk   (clk),
		.ctl   (mac_ctl),
		.coef  (coef),
		.st_val(st_val),
		.u_val (u_q),
		.gain  (gain_q),
		.ns_val(ns_val),
		.y_val (y_val),
		.sat   (y_sat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			chan_q      <= '0;
			u_q         <= '0;
			end_q       <= 1'b0;
			rd_a_s1     <= 1'b0;
			rd_b_s1     <= 1'b0;
			acc_a_s2    <= 1'b0;
			out_valid_q <= 1'b0;
			out_value_q <= '0;
			out_chan_q  <= '0;
			out_done_q  <= 1'b0;
			out_sat_q   <= 1'b0;
		end else begin
			rd_a_s1  <= st_rd_en;
			rd_b_s1  <= (state_q == ST_MAC) && (cnt_q == CW'(STATE_SIZE));
			acc_a_s2 <= rd_a_s1;
			// in the output stage a taken result is replaced by the new one
			if (m_tvalid && m_tready && (state_q != ST_OUT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (smp_go) begin
						chan_q  <= in_row;
						u_q     <= in_val;
						end_q   <= s_tlast;
						cnt_q   <= '0;
						state_q <= ST_MAC;
					end
				end
				ST_MAC: begin
					// A row, then B, then C read
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(STATE_SIZE + 1)) begin
						state_q <= ST_WB;
					end
				end
				ST_WB: begin
					state_q <= ST_MULC;
				end
				ST_MULC: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						out_value_q <= y_val;
						out_chan_q  <= chan_q;
						out_done_q  <= end_q;
						out_sat_q   <= y_sat;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_done_q;
	assign m_tdata  = {3'b000, out_sat_q, out_chan_q, out_value_q};

endmodule

`default_nettype wire

// ----- dv/sss_scan_checker.sv -----
`default_nettype none

module sss_scan_checker #(
	parameter int STATE_SIZE = 16,
	parameter int FRAC_BITS  = 12
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	// row_index[3:0], col_index[7:4], item_value[23:8], sequence_start[24], zero
	input  logic [sss_pkg::IN_DATA_W-1:0]  s_tdata,
	// req_type[1:0]
	input  logic [sss_pkg::IN_USER_W-1:0]  s_tuser,
	input  logic                           s_tlast,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	// output_value[15:0], out_channel[19:16], saturated[20], zero
	input  logic [sss_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                           m_tlast,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [sss_pkg::VAL_W-1:0]      cfg_data,
	input  logic                           end_check,
	output int                             pending,
	output int                             err_count,
	output int                             readouts_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	import sss_pkg::*;

	typedef struct {
		logic [VAL_W-1:0]  rd_value;
		logic [CHAN_W-1:0] rd_chan;
		logic              rd_last;
		logic              rd_clip;
	} readout_t;

	logic signed [VAL_W-1:0] a_coef [STATE_SIZE][STATE_SIZE];
	logic signed [VAL_W-1:0] b_coef [STATE_SIZE];
	logic signed [VAL_W-1:0] c_coef [STATE_SIZE];
	logic signed [VAL_W-1:0] cur_x  [STATE_SIZE];
	logic signed [VAL_W-1:0] nxt_x  [STATE_SIZE];
	logic signed [VAL_W-1:0] skip_gain;
	readout_t                readout_q [$];
	bit                      end_seen;

	task automatic report_mismatch(input string what);
		$display("%0t ns readout check: %s", $realtime, what);
		err_count++;
	endtask

	// rescale with round half up, then clip to 16 bits
	function automatic logic signed [VAL_W-1:0] round_clip(input longint acc, inout bit clip);
		longint r;
		r = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
		if (r > 32767) begin
			r = 32767;
			clip = 1'b1;
		end else if (r < -32768) begin
			r = -32768;
			clip = 1'b1;
		end
		return r[VAL_W-1:0];
	endfunction

	function automatic readout_t scan_channel(input logic [CHAN_W-1:0] row,
	                                          input logic signed [VAL_W-1:0] u,
	                                          input logic seq_start, input logic step_last);
		longint   acc;
		bit       clip;
		readout_t r;
		clip = 1'b0;
		if (seq_start) begin
			for (int j = 0; j < STATE_SIZE; j++) begin
				cur_x[j] = '0;
				nxt_x[j] = '0;
			end
		end
		acc = longint'(b_coef[row]) * longint'(u);
		for (int j = 0; j < STATE_SIZE; j++)
			acc += longint'(a_coef[row][j]) * longint'(cur_x[j]);
		nxt_x[row] = round_clip(acc, clip);
		acc = longint'(c_coef[row]) * longint'(nxt_x[row]) + longint'(skip_gain) * longint'(u);
		r.rd_value = round_clip(acc, clip);
		r.rd_chan  = row;
		r.rd_last  = step_last;
		r.rd_clip  = clip;
		// commit copies the whole bank, unsampled rows included
		if (step_last)
			for (int j = 0; j < STATE_SIZE; j++)
				cur_x[j] = nxt_x[j];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		readout_t          got, want;
		logic [CHAN_W-1:0] row, col;
		logic [VAL_W-1:0]  val;
		if (!arst_n) begin
			for (int j = 0; j < STATE_SIZE; j++) begin
				cur_x[j] = '0;
				nxt_x[j] = '0;
			end
			skip_gain = FT_GAIN_RST;
			readout_q.delete();
			end_seen = 1'b0;
			err_count = 0;
			readouts_checked = 0;
			pending <= 0;
		end else begin
			// results first so an item taken in the same cycle cannot be matched
			if (m_tvalid && m_tready) begin
				got.rd_value = m_tdata[15:0];
				got.rd_chan  = m_tdata[19:16];
				got.rd_clip  = m_tdata[20];
				got.rd_last  = m_tlast;
				if (readout_q.size() == 0) begin
					report_mismatch($sformatf("unexpected readout ch %0d value %h",
						got.rd_chan, got.rd_value));
				end else begin
					want = readout_q.pop_front();
					readouts_checked++;
					if (got.rd_value !== want.rd_value)
						report_mismatch($sformatf("ch %0d value got %h want %h",
							want.rd_chan, got.rd_value, want.rd_value));
					if (got.rd_chan !== want.rd_chan)
						report_mismatch($sformatf("channel got %0d want %0d",
							got.rd_chan, want.rd_chan));
					if (got.rd_last !== want.rd_last)
						report_mismatch($sformatf("ch %0d step_done got %b want %b",
							want.rd_chan, got.rd_last, want.rd_last));
					if (got.rd_clip !== want.rd_clip)
						report_mismatch($sformatf("ch %0d saturated got %b want %b",
							want.rd_chan, got.rd_clip, want.rd_clip));
				end
			end
			if (cfg_valid && cfg_ready)
				skip_gain = cfg_data;
			if (s_tvalid && s_tready) begin
				row = s_tdata[3:0];
				col = s_tdata[7:4];
				val = s_tdata[23:8];
				case (req_t'(s_tuser))
					REQ_LOAD_A: begin
						if (row < STATE_SIZE && col < STATE_SIZE)
							a_coef[row][col] = val;
					end
					REQ_LOAD_B: begin
						if (row < STATE_SIZE)
							b_coef[row] = val;
					end
					REQ_LOAD_C: begin
						if (row < STATE_SIZE)
							c_coef[row] = val;
					end
					REQ_SAMPLE: begin
						if (row < STATE_SIZE)
							readout_q.insert(readout_q.size(),
								scan_channel(row, val, s_tdata[24], s_tlast));
					end
					default: ;
				endcase
			end
			if (end_check && !end_seen) begin
				end_seen = 1'b1;
				if (readout_q.size() != 0)
					report_mismatch($sformatf("%0d readouts never came out", readout_q.size()));
			end
			pending <= readout_q.size();
		end
	end

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import sss_pkg::*;

	localparam int STATE_SIZE   = 16;
	localparam int FRAC_BITS    = 12;
	localparam int DRAIN_CYCLES = STATE_SIZE + 16;
	localparam int HOLD_CYCLES  = 400;
	localparam int SEGMENTS     = 6;
	localparam int SEG_ITEMS    = 22;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic [IN_USER_W-1:0]  s_tuser;
	logic                  s_tlast;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [VAL_W-1:0]      cfg_data;
	logic                  end_check;

	int pending;
	int err_count;
	int readouts_checked;
	int tx_idle_pct;
	int rx_idle_pct;
	bit hold_req;
	int n_samples;
	int n_loads;
	int n_gains;

	state_space_scan_step_unit #(
		.STATE_SIZE (STATE_SIZE),
		.FRAC_BITS  (FRAC_BITS)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	sss_scan_checker #(
		.STATE_SIZE (STATE_SIZE),
		.FRAC_BITS  (FRAC_BITS)
	) i_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.s_tvalid         (s_tvalid),
		.s_tready         (s_tready),
		.s_tdata          (s_tdata),
		.s_tuser          (s_tuser),
		.s_tlast          (s_tlast),
		.m_tvalid         (m_tvalid),
		.m_tready         (m_tready),
		.m_tdata          (m_tdata),
		.m_tlast          (m_tlast),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data),
		.end_check        (end_check),
		.pending          (pending),
		.err_count        (err_count),
		.readouts_checked (readouts_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("timeout, stream stuck");
		$display("FAILURE");
		$finish;
	end

	// output side: random back-pressure plus one long hold on request
	initial begin
		int hold_left;
		hold_left = 0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	function automatic logic [VAL_W-1:0] coef_value();
		case ($urandom_range(0, 9))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'($urandom);
			default: return 16'(int'($urandom_range(0, 1536)) - 768);
		endcase
	endfunction

	function automatic logic [VAL_W-1:0] sample_value();
		case ($urandom_range(0, 9))
			0: return 16'h7fff;
			1: return 16'h8000;
			2, 3: return 16'($urandom);
			default: return 16'(int'($urandom_range(0, 8192)) - 4096);
		endcase
	endfunction

	function automatic logic [VAL_W-1:0] gain_for_segment(input int seg);
		case (seg)
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'h0000;
			5: return FT_GAIN_RST;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic push_item(input req_t kind, input logic [3:0] row, input logic [3:0] col,
	                         input logic [VAL_W-1:0] val, input logic seq_start,
	                         input logic step_last);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'b0, seq_start, val, col, row};
		s_tuser  <= kind;
		s_tlast  <= step_last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (kind == REQ_SAMPLE)
			n_samples++;
		else
			n_loads++;
	endtask

	// the first edge lets the checker count an item taken at the last edge
	task automatic wait_results_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic write_gain(input logic [VAL_W-1:0] gain);
		wait_results_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= gain;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		n_gains++;
	endtask

	task automatic sample(input logic [3:0] row, input logic [VAL_W-1:0] u,
	                      input logic seq_start, input logic step_last);
		push_item(REQ_SAMPLE, row, 4'($urandom), u, seq_start, step_last);
	endtask

	task automatic random_run(input int n_items, input bit pause_midway);
		int         sent;
		int         step_len;
		int         base;
		bit         fresh;
		bit         paused;
		logic [3:0] row;
		sent = 0;
		paused = 1'b0;
		while (sent < n_items) begin
			if (pause_midway && !paused && sent >= n_items / 2) begin
				paused = 1'b1;
				wait_results_drained();
			end
			case ($urandom_range(0, 9))
				0: begin
					push_item(req_t'($urandom_range(0, 2)), 4'($urandom), 4'($urandom),
						coef_value(), 1'($urandom), 1'($urandom));
					sent++;
				end
				1: begin
					sample(4'($urandom), 16'($urandom), 1'($urandom), 1'($urandom));
					sent++;
				end
				default: begin
					// one time step over consecutive channels, sometimes opening a sequence
					step_len = $urandom_range(1, STATE_SIZE);
					base = $urandom_range(0, STATE_SIZE - 1);
					fresh = ($urandom_range(0, 3) == 0);
					for (int k = 0; k < step_len; k++) begin
						row = 4'((base + k) % STATE_SIZE);
						sample(row, sample_value(), fresh && k == 0, k == step_len - 1);
						sent++;
					end
				end
			endcase
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = REQ_LOAD_A;
		s_tlast = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		end_check = 1'b0;
		hold_req = 1'b0;
		tx_idle_pct = 32;
		rx_idle_pct = 45;
		n_samples = 0;
		n_loads = 0;
		n_gains = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every coefficient gets written before any sample reads it
		for (int r = 0; r < STATE_SIZE; r++)
			for (int c = 0; c < STATE_SIZE; c++)
				push_item(REQ_LOAD_A, 4'(r), 4'(c), coef_value(), 1'b0, 1'b0);
		for (int r = 0; r < STATE_SIZE; r++) begin
			push_item(REQ_LOAD_B, 4'(r), 4'($urandom), coef_value(), 1'b0, 1'b0);
			push_item(REQ_LOAD_C, 4'(r), 4'($urandom), coef_value(), 1'b0, 1'b0);
		end

		// rounding ties: +0.5 lsb goes up, -0.5 lsb goes up to zero
		push_item(REQ_LOAD_B, 4'd0, 4'd0, 16'h0800, 1'b0, 1'b0);
		push_item(REQ_LOAD_C, 4'd0, 4'd0, 16'h0000, 1'b0, 1'b0);
		sample(4'd0, 16'h0001, 1'b1, 1'b0);
		sample(4'd0, 16'hffff, 1'b1, 1'b1);
		// clipping both ways
		push_item(REQ_LOAD_B, 4'd1, 4'd15, 16'h7fff, 1'b1, 1'b1);
		push_item(REQ_LOAD_C, 4'd1, 4'd15, 16'h7fff, 1'b0, 1'b0);
		sample(4'd1, 16'h7fff, 1'b1, 1'b0);
		sample(4'd1, 16'h8000, 1'b0, 1'b1);
		// extreme coefficients on the last row
		push_item(REQ_LOAD_A, 4'd15, 4'd15, 16'h8000, 1'b0, 1'b0);
		push_item(REQ_LOAD_A, 4'd15, 4'd0, 16'h7fff, 1'b0, 1'b0);
		push_item(REQ_LOAD_B, 4'd15, 4'd0, 16'h8000, 1'b0, 1'b0);
		push_item(REQ_LOAD_C, 4'd15, 4'd0, 16'h8000, 1'b0, 1'b0);
		sample(4'd15, 16'h8000, 1'b0, 1'b1);
		sample(4'd15, 16'h0000, 1'b0, 1'b1);
		// commit carries rows not sampled since the last clear
		sample(4'd2, 16'h1000, 1'b1, 1'b0);
		sample(4'd3, 16'h1000, 1'b0, 1'b1);
		sample(4'd4, 16'h0000, 1'b0, 1'b1);
		sample(4'd2, 16'h0000, 1'b0, 1'b1);
		sample(4'd4, 16'h0000, 1'b1, 1'b1);
		push_item(REQ_LOAD_A, 4'd0, 4'd15, 16'($urandom), 1'b0, 1'b0);

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			write_gain(gain_for_segment(seg));
			tx_idle_pct = (seg < 2) ? 32 : (seg < 4) ? 45 : 0;
			rx_idle_pct = (seg < 2) ? 45 : (seg < 4) ? 32 : 0;
			if (seg == 0)
				hold_req = 1'b1;
			random_run(SEG_ITEMS, seg == 3);
		end

		wait_results_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		end_check <= 1'b1;
		repeat (2) @(posedge clk);

		$display("sent %0d items: %0d samples and %0d coefficient loads, %0d readouts checked",
			n_samples + n_loads, n_samples, n_loads, readouts_checked);
		$display("skip gain set %0d times incl. both extremes, three idle mixes, one long stall",
			n_gains);
		if (err_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire
